// ----- design/rfa_pkg.sv -----
`timescale 1ns / 1ps
// Package for the rational fraction ALU: mode codes and fixed widths.
// No dependencies; imported by rational_fraction_alu.
package rfa_pkg;

  localparam int unsigned ModeW = 3;
  localparam int unsigned ResW  = 33;
  localparam int unsigned AccW  = 64;
  localparam int unsigned CntW  = 6;

  typedef logic [ModeW-1:0] mode_t;

  localparam mode_t MODE_ADD = 3'd0;
  localparam mode_t MODE_SUB = 3'd1;
  localparam mode_t MODE_MUL = 3'd2;
  localparam mode_t MODE_DIV = 3'd3;

endpackage

// ----- design/rational_fraction_alu.sv -----
`timescale 1ns / 1ps
// Channel  | signals                                          | dir | handshake
// request  | mode_i, a_num_i, a_den_i, b_num_i, b_den_i       | in  | start_i && !busy_o
// result   | res_num_o, res_den_o, zero_gcd_error_o           | out | res_valid_o, one cycle
//
// A request runs multiply states ST_MUL0, ST_MUL1 and, for add and subtract, ST_MUL2 on one
// signed multiplier, takes magnitudes, runs binary GCD steps (shift or subtract) and then
// two restoring divisions, numerator then denominator, by the GCD; a zero over zero
// request answers from the magnitude step. The shared 65-bit subtractor sets the pace.
// Reset clears the sequencer and the strobe. The receiver cannot stall: each result is
// shown for exactly one cycle, and busy_o is low again in that same cycle.
// Depends on rfa_pkg.
module rational_fraction_alu #(
  parameter int unsigned OPERAND_WIDTH = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  rfa_pkg::mode_t                    mode_i,
  input  logic signed [OPERAND_WIDTH-1:0]   a_num_i,
  input  logic signed [OPERAND_WIDTH-1:0]   a_den_i,
  input  logic signed [OPERAND_WIDTH-1:0]   b_num_i,
  input  logic signed [OPERAND_WIDTH-1:0]   b_den_i,
  output logic                              res_valid_o,
  output logic signed [rfa_pkg::ResW-1:0]   res_num_o,
  output logic signed [rfa_pkg::ResW-1:0]   res_den_o,
  output logic                              zero_gcd_error_o
);
  import rfa_pkg::*;

  localparam int unsigned PW = 2 * OPERAND_WIDTH;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL0, ST_MUL1, ST_MUL2, ST_ABS, ST_GCD, ST_DIVN, ST_DIVD
  } state_e;

  state_e state_q;
  mode_t  mode_q;
  logic signed [OPERAND_WIDTH-1:0] an_q, ad_q, bn_q, bd_q;
  logic [AccW-1:0] num_q, den_q, x_q, y_q, g_q, dvd_q, rem_q;
  logic [CntW-1:0] k_q, cnt_q;
  logic neg_num_q, neg_den_q;

  logic signed [OPERAND_WIDTH-1:0] mul_a, mul_b;
  logic signed [PW-1:0]            prod;
  logic [AccW-1:0]                 prod64;
  logic [AccW:0]                   sub_a, sub_b, sub_r;
  logic [AccW-1:0]                 q_next, num_mag, den_mag;

  // Operand selection for the single multiplier.
  always_comb begin
    mul_a = (state_q == ST_MUL0) ? an_q : ad_q;
    case (state_q)
      ST_MUL0: mul_b = (mode_q == MODE_MUL) ? bn_q : bd_q;
      ST_MUL1: mul_b = (mode_q == MODE_DIV) ? bn_q : bd_q;
      default: mul_b = bn_q;
    endcase
  end

  assign prod   = mul_a * mul_b;
  assign prod64 = AccW'(prod);

  // Shared subtractor: GCD compare-and-subtract, or one restoring division step.
  always_comb begin
    if (state_q == ST_GCD) begin
      sub_a = {1'b0, x_q};
      sub_b = {1'b0, y_q};
    end else begin
      sub_a = {rem_q, dvd_q[AccW-1]};
      sub_b = {1'b0, g_q};
    end
  end

  assign sub_r   = sub_a - sub_b;
  assign q_next  = {dvd_q[AccW-2:0], ~sub_r[AccW]};
  assign num_mag = num_q[AccW-1] ? (AccW'(0) - num_q) : num_q;
  assign den_mag = den_q[AccW-1] ? (AccW'(0) - den_q) : den_q;
  assign busy_o  = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      res_valid_o <= 1'b0;
    end else begin
      res_valid_o <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            mode_q  <= mode_i;
            an_q    <= a_num_i;
            ad_q    <= a_den_i;
            bn_q    <= b_num_i;
            bd_q    <= b_den_i;
            state_q <= ST_MUL0;
          end
        end
        ST_MUL0: begin
          case (mode_q)
            MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV: begin
              num_q   <= prod64;
              state_q <= ST_MUL1;
            end
            default: begin
              num_q   <= AccW'(an_q);
              den_q   <= AccW'(ad_q);
              state_q <= ST_ABS;
            end
          endcase
        end
        ST_MUL1: begin
          den_q   <= prod64;
          state_q <= (mode_q == MODE_ADD || mode_q == MODE_SUB) ? ST_MUL2 : ST_ABS;
        end
        ST_MUL2: begin
          num_q   <= (mode_q == MODE_ADD) ? (num_q + prod64) : (num_q - prod64);
          state_q <= ST_ABS;
        end
        ST_ABS: begin
          neg_num_q <= num_q[AccW-1];
          neg_den_q <= den_q[AccW-1];
          x_q       <= num_mag;
          y_q       <= den_mag;
          k_q       <= '0;
          if (num_q == '0 && den_q == '0) begin
            res_num_o        <= '0;
            res_den_o        <= '0;
            zero_gcd_error_o <= 1'b1;
            res_valid_o      <= 1'b1;
            state_q          <= ST_IDLE;
          end else begin
            state_q <= ST_GCD;
          end
        end
        ST_GCD: begin
          // Binary GCD: strip common twos, then odd-minus-odd until one side is zero.
          if (x_q == '0 || y_q == '0) begin
            g_q     <= (x_q | y_q) << k_q;
            dvd_q   <= num_mag;
            rem_q   <= '0;
            cnt_q   <= '0;
            state_q <= ST_DIVN;
          end else if (!x_q[0] && !y_q[0]) begin
            x_q <= x_q >> 1;
            y_q <= y_q >> 1;
            k_q <= k_q + 1'b1;
          end else if (!x_q[0]) begin
            x_q <= x_q >> 1;
          end else if (!y_q[0]) begin
            y_q <= y_q >> 1;
          end else if (!sub_r[AccW]) begin
            x_q <= sub_r[AccW-1:0];
          end else begin
            y_q <= AccW'(0) - sub_r[AccW-1:0];
          end
        end
        ST_DIVN, ST_DIVD: begin
          rem_q <= sub_r[AccW] ? sub_a[AccW-1:0] : sub_r[AccW-1:0];
          dvd_q <= q_next;
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CntW'(AccW - 1)) begin
            rem_q <= '0;
            if (state_q == ST_DIVN) begin
              // The numerator quotient replaces the numerator; its sign is kept apart.
              num_q   <= q_next;
              dvd_q   <= den_mag;
              state_q <= ST_DIVD;
            end else begin
              res_num_o        <= ResW'(neg_num_q ? (AccW'(0) - num_q) : num_q);
              res_den_o        <= ResW'(neg_den_q ? (AccW'(0) - q_next) : q_next);
              zero_gcd_error_o <= 1'b0;
              res_valid_o      <= 1'b1;
              state_q          <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && zero_gcd_error_o |-> res_num_o == '0 && res_den_o == '0)
    else $error("zero GCD result is not zero");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("accepted request did not raise busy");

  a_valid_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> !busy_o)
    else $error("result strobe while sequencer busy");

  a_gcd_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_GCD |-> (x_q != '0 || y_q != '0))
    else $error("GCD entered with both operands zero");

endmodule
